// ===== rtl/pixel_frame_shift_with_wrap_assert.svh =====
// Assertion macros for the pixel frame shifter RTL.
// Each use names a label, a property and a message; the clock is clk and
// the reset of PFSW_ASSERT is rst_n in the module that uses them.
`ifndef PIXEL_FRAME_SHIFT_WITH_WRAP_ASSERT_SVH
`define PIXEL_FRAME_SHIFT_WITH_WRAP_ASSERT_SVH

`ifndef SYNTHESIS
`define PFSW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFSW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFSW_ASSERT(lbl, prop, msg)
`define PFSW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/pfsw_pkg.sv =====
package pfsw_pkg;

    // Grid size
    localparam int GRID_ROWS = 16;
    localparam int GRID_COLS = 8;
    localparam int ROW_IDX_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int COL_IDX_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

    // Beat field widths
    localparam int MODE_W  = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 4;
    localparam int COLOR_W = 24;
    localparam int DIR_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = MODE_W;
    localparam int M_DATA_W = COLOR_W;
    localparam int M_USER_W = 1;

    // Register map
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] ADDR_WRAP = 3'd0;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_SHIFT = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT       = 3'd0,
        DIR_RIGHT      = 3'd1,
        DIR_UP         = 3'd2,
        DIR_DOWN       = 3'd3,
        DIR_UP_LEFT    = 3'd4,
        DIR_UP_RIGHT   = 3'd5,
        DIR_DOWN_LEFT  = 3'd6,
        DIR_DOWN_RIGHT = 3'd7
    } dir_t;

    typedef struct packed {
        mode_t              mode;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COLOR_W-1:0] color;
        dir_t               direction;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               status;
    } result_t;

endpackage

// ===== rtl/pfsw_in_reg.sv =====
module pfsw_in_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfsw_pkg::S_DATA_W-1:0] s_tdata,  // row, col, color, direction
    input  logic [pfsw_pkg::S_USER_W-1:0] s_tuser,  // mode
    input  logic                          out_free,
    output pfsw_pkg::item_t               item,
    output logic                          adv
);

    logic            valid_reg;
    logic            valid_next;
    pfsw_pkg::item_t item_reg;
    pfsw_pkg::item_t item_in;

    // Unpack the incoming beat
    always_comb
    begin
        item_in.mode      = pfsw_pkg::mode_t'(s_tuser[pfsw_pkg::MODE_W-1:0]);
        item_in.row       = s_tdata[4:0];
        item_in.col       = s_tdata[8:5];
        item_in.color     = s_tdata[32:9];
        item_in.direction = pfsw_pkg::dir_t'(s_tdata[35:33]);
    end

    // Advance the held item when the result register can take it
    assign adv      = valid_reg && out_free;
    assign s_tready = !valid_reg || adv;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (adv)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each accepted beat
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

// ===== rtl/pfsw_frame.sv =====
module pfsw_frame (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wrap_enable,
    input  logic              adv,
    input  pfsw_pkg::item_t   item,
    output pfsw_pkg::result_t result
);

    localparam int ROWS = pfsw_pkg::GRID_ROWS;
    localparam int COLS = pfsw_pkg::GRID_COLS;

    logic [pfsw_pkg::COLOR_W-1:0] pix_reg  [ROWS][COLS];
    logic [pfsw_pkg::COLOR_W-1:0] pix_next [ROWS][COLS];

    logic                           in_range;
    logic                           is_access;
    logic [pfsw_pkg::ROW_IDX_W-1:0] row_idx;
    logic [pfsw_pkg::COL_IDX_W-1:0] col_idx;

    // Check the pixel address against the grid
    assign in_range  = ({1'b0, item.row} < (pfsw_pkg::ROW_W+1)'(ROWS))
                    && ({1'b0, item.col} < (pfsw_pkg::COL_W+1)'(COLS));
    assign is_access = (item.mode == pfsw_pkg::MODE_WRITE)
                    || (item.mode == pfsw_pkg::MODE_READ);
    assign row_idx   = item.row[pfsw_pkg::ROW_IDX_W-1:0];
    assign col_idx   = item.col[pfsw_pkg::COL_IDX_W-1:0];

    // Read port and status
    always_comb
    begin
        result.status     = is_access && !in_range;
        result.read_color = '0;
        if ((item.mode == pfsw_pkg::MODE_READ) && in_range)
        begin
            result.read_color = pix_reg[row_idx][col_idx];
        end
    end

    // One cell per pixel: shift source selection, write and hold
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < COLS; c++)
        begin : g_col
            localparam int  RU   = (r + 1) % ROWS;
            localparam int  RD   = (r + ROWS - 1) % ROWS;
            localparam int  CL   = (c + 1) % COLS;
            localparam int  CR   = (c + COLS - 1) % COLS;
            localparam bit  U_IN = (r + 1 < ROWS);
            localparam bit  D_IN = (r > 0);
            localparam bit  L_IN = (c + 1 < COLS);
            localparam bit  R_IN = (c > 0);

            logic [pfsw_pkg::COLOR_W-1:0] shift_pix;

            // Pick the neighbour moving into this cell; unwrapped edges fill black
            always_comb
            begin
                shift_pix = '0;
                case (item.direction)
                    pfsw_pkg::DIR_LEFT:
                    begin
                        if (L_IN || wrap_enable) shift_pix = pix_reg[r][CL];
                    end
                    pfsw_pkg::DIR_RIGHT:
                    begin
                        if (R_IN || wrap_enable) shift_pix = pix_reg[r][CR];
                    end
                    pfsw_pkg::DIR_UP:
                    begin
                        if (U_IN || wrap_enable) shift_pix = pix_reg[RU][c];
                    end
                    pfsw_pkg::DIR_DOWN:
                    begin
                        if (D_IN || wrap_enable) shift_pix = pix_reg[RD][c];
                    end
                    pfsw_pkg::DIR_UP_LEFT:
                    begin
                        if (U_IN && L_IN) shift_pix = pix_reg[RU][CL];
                    end
                    pfsw_pkg::DIR_UP_RIGHT:
                    begin
                        if (U_IN && R_IN) shift_pix = pix_reg[RU][CR];
                    end
                    pfsw_pkg::DIR_DOWN_LEFT:
                    begin
                        if (D_IN && L_IN) shift_pix = pix_reg[RD][CL];
                    end
                    pfsw_pkg::DIR_DOWN_RIGHT:
                    begin
                        if (D_IN && R_IN) shift_pix = pix_reg[RD][CR];
                    end
                    default:
                    begin
                        shift_pix = '0;
                    end
                endcase
            end

            always_comb
            begin
                pix_next[r][c] = pix_reg[r][c];
                if (adv)
                begin
                    if ((item.mode == pfsw_pkg::MODE_WRITE) && in_range
                        && (item.row == pfsw_pkg::ROW_W'(r))
                        && (item.col == pfsw_pkg::COL_W'(c)))
                    begin
                        pix_next[r][c] = item.color;
                    end
                    else if (item.mode == pfsw_pkg::MODE_SHIFT)
                    begin
                        pix_next[r][c] = shift_pix;
                    end
                end
            end

            // Frame comes up black
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pix_reg[r][c] <= '0;
                end
                else
                begin
                    pix_reg[r][c] <= pix_next[r][c];
                end
            end
        end
    end

endmodule

// ===== rtl/pfsw_out_reg.sv =====
module pfsw_out_reg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  pfsw_pkg::result_t             result,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pfsw_pkg::M_DATA_W-1:0] m_tdata,  // read_color
    output logic [pfsw_pkg::M_USER_W-1:0] m_tuser   // status
);

    logic              valid_reg;
    logic              valid_next;
    pfsw_pkg::result_t result_reg;

    // Free when empty or the held beat leaves this cycle
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.read_color;
    assign m_tuser  = result_reg.status;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/pixel_frame_shift_with_wrap.sv =====
// Pixel frame store with whole-frame shift. Holds a GRID_ROWS x GRID_COLS
// frame of 24-bit RGB pixels in flip-flops, black after reset (no clearing
// pass; the frame is usable from the first cycle). Each input beat writes a
// pixel, reads a pixel, shifts the frame one place in one of eight
// directions or does nothing (NOP), and yields exactly one result beat. The
// block takes one beat per clock while m_tready is high: a beat sits in the
// item register while the frame logic reads, writes or shifts every pixel
// in parallel, and its result is loaded into the result register when the
// item advances, which it does only while that register is free.
// Throughput is bounded only by the downstream tready. Register 0 (wrap
// enable, address 0x0) makes left, right, up and down shifts rotate; write it
// only while no beat is in flight.
`include "pixel_frame_shift_with_wrap_assert.svh"

module pixel_frame_shift_with_wrap (
    input  logic                            clk,
    input  logic                            rst_n,
    // Item stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pfsw_pkg::S_DATA_W-1:0]   s_tdata,  // row, col, color, direction
    input  logic [pfsw_pkg::S_USER_W-1:0]   s_tuser,  // mode
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pfsw_pkg::M_DATA_W-1:0]   m_tdata,  // read_color
    output logic [pfsw_pkg::M_USER_W-1:0]   m_tuser,  // status
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pfsw_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic              wrap_reg;
    logic              wrap_next;
    logic              out_free;
    logic              adv;
    pfsw_pkg::item_t   item;
    pfsw_pkg::result_t result;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == pfsw_pkg::ADDR_WRAP) ? {31'b0, wrap_reg} : 32'b0;

    always_comb
    begin
        wrap_next = wrap_reg;
        if (psel && penable && pwrite && pready && (paddr == pfsw_pkg::ADDR_WRAP))
        begin
            wrap_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_reg <= 1'b0;
        end
        else
        begin
            wrap_reg <= wrap_next;
        end
    end

    pfsw_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .out_free (out_free),
        .item     (item),
        .adv      (adv)
    );

    pfsw_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_enable (wrap_reg),
        .adv         (adv),
        .item        (item),
        .result      (result)
    );

    pfsw_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Input side never stalls while the result register has room
    `PFSW_ASSERT_ALWAYS(a_ready_when_free, out_free |-> s_tready, "input stalled with free output")
    // An advancing item always produces a result beat
    `PFSW_ASSERT(a_adv_gives_result, adv |=> m_tvalid, "advanced item lost")
    // A rejected access returns black
    `PFSW_ASSERT(a_reject_black, (m_tvalid && m_tuser[0]) |-> (m_tdata == '0), "reject not black")

endmodule
